// ----- sv/rfrs_pkg.sv -----
// Shared constants and types for the rounded frame row span block.
`timescale 1ns / 1ps

package rfrs_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int ROOT_STEPS_DEF = 16;

  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           style_t;

  localparam cfg_idx_t REG_CLIP_ENABLE   = 3'd0;
  localparam cfg_idx_t REG_FRAME_LEFT    = 3'd1;
  localparam cfg_idx_t REG_FRAME_TOP     = 3'd2;
  localparam cfg_idx_t REG_FRAME_WIDTH   = 3'd3;
  localparam cfg_idx_t REG_FRAME_HEIGHT  = 3'd4;
  localparam cfg_idx_t REG_CORNER_RADIUS = 3'd5;
  localparam cfg_idx_t REG_CORNER_STYLES = 3'd6;

  localparam style_t STYLE_SQUARE = 2'd0;
  localparam style_t STYLE_ROUND  = 2'd1;
  localparam style_t STYLE_MITRE  = 2'd2;
  localparam style_t STYLE_PLAIN  = 2'd3;

endpackage

// ----- sv/rfrs_front.sv -----
// Front stages: frame containment, radius clamp, corner band, squares and root operand.
`timescale 1ns / 1ps

module rfrs_front
  import rfrs_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ROOT_STEPS = ROOT_STEPS_DEF,
  localparam int POS_BITS  = COORD_BITS + 1,
  localparam int OUT_BITS  = COORD_BITS + 2,
  localparam int SIDE_W    = 2 * COORD_BITS + 5,
  localparam int ROOT_W    = 2 * ROOT_STEPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clip_enable,
  input  logic [POS_BITS-1:0]   frame_top,
  input  logic [COORD_BITS-1:0] frame_width,
  input  logic [COORD_BITS-1:0] frame_height,
  input  logic [COORD_BITS-1:0] corner_radius,
  input  logic [7:0]            corner_styles,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROOT_W-1:0]     out_operand,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIFF_W = (SQ_W > ROOT_W) ? SQ_W : ROOT_W;

  logic en_a, en_b, en_c, en_d;

  // stage A: containment
  logic                  a_vld_r, a_inside_r;
  logic [COORD_BITS-1:0] a_off_r;
  logic signed [OUT_BITS-1:0] row_s, top_s, bot_s, off_s;
  logic inside_nxt;

  assign row_s = $signed({2'b00, in_row});
  assign top_s = $signed({frame_top[POS_BITS-1], frame_top});
  assign bot_s = top_s + $signed({2'b00, frame_height});
  assign off_s = row_s - top_s;
  assign inside_nxt = clip_enable && (row_s >= top_s) && (row_s < bot_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en_a) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_inside_r <= inside_nxt;
      a_off_r    <= off_s[COORD_BITS-1:0];
    end
  end

  // stage B: clamp radius, pick band and corner styles
  logic [COORD_BITS-1:0] half_w, half_h, rc, depth, dy_nxt;
  logic                  top_band, bot_band, span_nxt;
  style_t                sl_nxt, sr_nxt;
  logic                  b_vld_r;
  logic [SIDE_W-1:0]     b_side_r;
  logic [COORD_BITS-1:0] b_rc_r, b_dy_r;

  assign half_w = frame_width >> 1;
  assign half_h = frame_height >> 1;

  always_comb begin
    rc = corner_radius;
    if (rc > half_w) rc = half_w;
    if (rc > half_h) rc = half_h;
  end

  assign top_band = a_off_r < rc;
  assign bot_band = ({1'b0, a_off_r} + {1'b0, rc}) >= {1'b0, frame_height};
  assign depth    = top_band ? a_off_r : frame_height - COORD_BITS'(1) - a_off_r;
  assign dy_nxt   = rc - depth;
  assign span_nxt = a_inside_r && (rc != '0) && (top_band || bot_band);
  assign sl_nxt   = top_band ? corner_styles[1:0] : corner_styles[7:6];
  assign sr_nxt   = top_band ? corner_styles[3:2] : corner_styles[5:4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en_b) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_side_r <= {span_nxt, rc, dy_nxt, sl_nxt, sr_nxt};
      b_rc_r   <= rc;
      b_dy_r   <= dy_nxt;
    end
  end

  // stage C: squares
  logic              c_vld_r;
  logic [SQ_W-1:0]   c_rr_r, c_dd_r;
  logic [SIDE_W-1:0] c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en_c) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_rr_r   <= SQ_W'(b_rc_r) * SQ_W'(b_rc_r);
      c_dd_r   <= SQ_W'(b_dy_r) * SQ_W'(b_dy_r);
      c_side_r <= b_side_r;
    end
  end

  // stage D: root operand, low root bits only
  logic              d_vld_r;
  logic [ROOT_W-1:0] d_operand_r;
  logic [SIDE_W-1:0] d_side_r;
  logic [DIFF_W-1:0] diff_ext;

  assign diff_ext = DIFF_W'(c_rr_r - c_dd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en_d) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_operand_r <= diff_ext[ROOT_W-1:0];
      d_side_r    <= c_side_r;
    end
  end

  // a stage advances when empty or when the next one advances
  assign en_d = !d_vld_r || out_ready;
  assign en_c = !c_vld_r || en_d;
  assign en_b = !b_vld_r || en_c;
  assign en_a = !a_vld_r || en_b;

  assign in_ready    = en_a;
  assign out_valid   = d_vld_r;
  assign out_operand = d_operand_r;
  assign out_side    = d_side_r;

endmodule

// ----- sv/rfrs_root.sv -----
// Pipelined restoring square root, one result bit per stage, with a side word.
`timescale 1ns / 1ps

module rfrs_root #(
  parameter int ROOT_STEPS = 16,
  parameter int SIDE_W     = 29,
  localparam int ROOT_W    = 2 * ROOT_STEPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ROOT_W-1:0]     in_operand,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROOT_STEPS-1:0] out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int RW  = ROOT_STEPS + 2;
  localparam int RTW = ROOT_STEPS + 1;

  logic              vld_q  [0:ROOT_STEPS];
  logic [RW-1:0]     rem_q  [0:ROOT_STEPS];
  logic [RTW-1:0]    root_q [0:ROOT_STEPS];
  logic [ROOT_W-1:0] opd_q  [0:ROOT_STEPS];
  logic [SIDE_W-1:0] side_q [0:ROOT_STEPS];
  logic [ROOT_STEPS:0] en;

  assign vld_q[0]  = in_valid;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign opd_q[0]  = in_operand;
  assign side_q[0] = in_side;
  assign en[ROOT_STEPS] = out_ready;

  for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_stage
    logic              vld_r;
    logic [RW-1:0]     rem_r, rem_sh, rem_nxt;
    logic [RTW-1:0]    root_r, root_sh, root_nxt;
    logic [ROOT_W-1:0] opd_r;
    logic [SIDE_W-1:0] side_r;
    logic              take;

    // bring down the next two operand bits, try the trial divisor
    assign root_sh  = {root_q[s][RTW-2:0], 1'b0};
    assign rem_sh   = {rem_q[s][RW-3:0], opd_q[s][ROOT_W-1 -: 2]};
    assign take     = RW'(root_sh) < rem_sh;
    assign rem_nxt  = take ? rem_sh - (RW'(root_sh) | RW'(1)) : rem_sh;
    assign root_nxt = take ? root_sh + RTW'(2) : root_sh;

    assign en[s] = !vld_r || en[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en[s]) begin
        vld_r <= vld_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        opd_r  <= opd_q[s] << 2;
        side_r <= side_q[s];
      end
    end

    assign vld_q[s+1]  = vld_r;
    assign rem_q[s+1]  = rem_r;
    assign root_q[s+1] = root_r;
    assign opd_q[s+1]  = opd_r;
    assign side_q[s+1] = side_r;
  end

  assign in_ready  = en[0];
  assign out_valid = vld_q[ROOT_STEPS];
  assign out_root  = root_q[ROOT_STEPS][RTW-1:1];
  assign out_side  = side_q[ROOT_STEPS];

endmodule

// ----- sv/rounded_frame_row_span_top.sv -----
// Four front stages, one stage per root bit and one output stage lie between accepted row and result word.
// Throughput: one row per cycle while the output word is being taken.
// Any stage holds its word while the next is full, so stalls lose and repeat nothing.
// The output register takes a new word whenever it is empty or being taken.
// Reset (synchronous, active low) clears the frame registers and all valid bits.
`timescale 1ns / 1ps

module rounded_frame_row_span_top
  import rfrs_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ROOT_STEPS = ROOT_STEPS_DEF,
  localparam int POS_BITS  = COORD_BITS + 1,
  localparam int OUT_BITS  = COORD_BITS + 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  cfg_idx_t                   cfg_index,
  input  logic [POS_BITS-1:0]        cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [COORD_BITS-1:0]      in_screen_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_span_valid,
  output logic signed [OUT_BITS-1:0] out_span_start,
  output logic signed [OUT_BITS-1:0] out_span_end
);

  localparam int SIDE_W = 2 * COORD_BITS + 5;
  localparam int ROOT_W = 2 * ROOT_STEPS;

  logic                  clip_enable_r;
  logic [POS_BITS-1:0]   frame_left_r, frame_top_r;
  logic [COORD_BITS-1:0] frame_width_r, frame_height_r, corner_radius_r;
  logic [7:0]            corner_styles_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_enable_r   <= 1'b0;
      frame_left_r    <= '0;
      frame_top_r     <= '0;
      frame_width_r   <= '0;
      frame_height_r  <= '0;
      corner_radius_r <= '0;
      corner_styles_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLIP_ENABLE:   clip_enable_r   <= cfg_wdata[0];
        REG_FRAME_LEFT:    frame_left_r    <= cfg_wdata;
        REG_FRAME_TOP:     frame_top_r     <= cfg_wdata;
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[COORD_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_CORNER_RADIUS: corner_radius_r <= cfg_wdata[COORD_BITS-1:0];
        REG_CORNER_STYLES: corner_styles_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic              fr_valid, fr_ready;
  logic [ROOT_W-1:0] fr_operand;
  logic [SIDE_W-1:0] fr_side;

  rfrs_front #(
    .COORD_BITS (COORD_BITS),
    .ROOT_STEPS (ROOT_STEPS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .clip_enable   (clip_enable_r),
    .frame_top     (frame_top_r),
    .frame_width   (frame_width_r),
    .frame_height  (frame_height_r),
    .corner_radius (corner_radius_r),
    .corner_styles (corner_styles_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_row        (in_screen_row),
    .out_valid     (fr_valid),
    .out_ready     (fr_ready),
    .out_operand   (fr_operand),
    .out_side      (fr_side)
  );

  logic                  rt_valid, rt_ready;
  logic [ROOT_STEPS-1:0] rt_root;
  logic [SIDE_W-1:0]     rt_side;

  rfrs_root #(
    .ROOT_STEPS (ROOT_STEPS),
    .SIDE_W     (SIDE_W)
  ) u_root (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (fr_valid),
    .in_ready   (fr_ready),
    .in_operand (fr_operand),
    .in_side    (fr_side),
    .out_valid  (rt_valid),
    .out_ready  (rt_ready),
    .out_root   (rt_root),
    .out_side   (rt_side)
  );

  // unpack side word: span flag, clamped radius, dy, left style, right style
  logic                  sd_span;
  logic [COORD_BITS-1:0] sd_r, sd_dy;
  style_t                sd_sl, sd_sr;

  assign sd_span = rt_side[SIDE_W-1];
  assign sd_r    = rt_side[SIDE_W-2 -: COORD_BITS];
  assign sd_dy   = rt_side[SIDE_W-2-COORD_BITS -: COORD_BITS];
  assign sd_sl   = rt_side[3:2];
  assign sd_sr   = rt_side[1:0];

  function automatic logic [OUT_BITS-1:0] corner_inset(
    input style_t                st,
    input logic [COORD_BITS-1:0] r,
    input logic [COORD_BITS-1:0] dy,
    input logic [ROOT_STEPS-1:0] root
  );
    logic [OUT_BITS-1:0] res;
    unique case (st)
      STYLE_MITRE: res = OUT_BITS'(dy);
      STYLE_ROUND: res = OUT_BITS'(r) - OUT_BITS'(root);
      STYLE_SQUARE, STYLE_PLAIN: res = '0;
      default: res = '0;
    endcase
    return res;
  endfunction

  logic [OUT_BITS-1:0] left_ext, width_ext, inset_l, inset_r, x0_nxt, x1_nxt;

  assign left_ext  = {frame_left_r[POS_BITS-1], frame_left_r};
  assign width_ext = OUT_BITS'(frame_width_r);
  assign inset_l   = corner_inset(sd_sl, sd_r, sd_dy, rt_root);
  assign inset_r   = corner_inset(sd_sr, sd_r, sd_dy, rt_root);
  assign x0_nxt    = sd_span ? left_ext + inset_l : '0;
  assign x1_nxt    = sd_span ? left_ext + width_ext - inset_r : '0;

  logic                out_valid_r, span_valid_r;
  logic [OUT_BITS-1:0] span_start_r, span_end_r;
  logic                out_en;

  assign out_en   = !out_valid_r || out_ready;
  assign rt_ready = out_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      span_valid_r <= sd_span;
      span_start_r <= x0_nxt;
      span_end_r   <= x1_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_valid = span_valid_r;
  assign out_span_start = $signed(span_start_r);
  assign out_span_end   = $signed(span_end_r);

  // an invalid span word carries zero bounds
  a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_span_valid |-> out_span_start == '0 && out_span_end == '0)
    else $error("invalid span word with nonzero bounds");

  // clipping off never yields a limited row
  a_clip_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !clip_enable_r |-> !out_span_valid)
    else $error("span valid while clipping disabled");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// ----- verif/rfrs_span_checker.sv -----
// Watches the row and span channels of the rounded frame row span block and checks each span.
`timescale 1ns / 1ps

module rfrs_span_checker
  import rfrs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  cfg_idx_t                     cfg_index,
  input  logic [COORD_BITS_DEF:0]      cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [COORD_BITS_DEF-1:0]    in_screen_row,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_span_valid,
  input  logic signed [COORD_BITS_DEF+1:0] out_span_start,
  input  logic signed [COORD_BITS_DEF+1:0] out_span_end,
  output int                           fail_count,
  output int                           pending_count
);

  localparam int COORD_BITS = COORD_BITS_DEF;
  localparam int POS_BITS   = COORD_BITS + 1;
  localparam int OUT_BITS   = COORD_BITS + 2;
  localparam int ROOT_STEPS = ROOT_STEPS_DEF;
  localparam longint unsigned ROOT_MASK = (64'd1 << (2 * ROOT_STEPS)) - 64'd1;

  typedef struct packed {
    logic [COORD_BITS-1:0]      row;
    logic                       span_valid;
    logic signed [OUT_BITS-1:0] x_from;
    logic signed [OUT_BITS-1:0] x_to;
  } span_word_t;

  // Shadow of the frame registers, updated from the write port
  logic                  clip_on;
  logic [POS_BITS-1:0]   left_q;
  logic [POS_BITS-1:0]   top_q;
  logic [COORD_BITS-1:0] width_q;
  logic [COORD_BITS-1:0] height_q;
  logic [COORD_BITS-1:0] radius_q;
  logic [7:0]            styles_q;

  span_word_t span_expected_q[$];
  int         mism;

  // Restoring bitwise square root, one result bit per step
  function automatic longint unsigned bit_sqrt(input longint unsigned v);
    longint unsigned rem;
    longint unsigned acc;
    rem = 0;
    acc = 0;
    for (int i = ROOT_STEPS - 1; i >= 0; i--) begin
      acc = acc << 1;
      rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      if (acc < rem) begin
        rem = rem - (acc | 64'd1);
        acc = acc + 64'd2;
      end
    end
    return acc >> 1;
  endfunction

  function automatic longint corner_inset(input style_t st, input longint r,
                                          input longint depth);
    longint unsigned dy;
    longint unsigned sq;
    if (st == STYLE_MITRE) return r - depth;
    if (st == STYLE_ROUND) begin
      dy = r - depth;
      sq = (r * r - dy * dy) & ROOT_MASK;
      return r - longint'(bit_sqrt(sq));
    end
    return 0;
  endfunction

  function automatic span_word_t predict_row_span(input logic [COORD_BITS-1:0] row_bits);
    longint row, left, top, w, h, r, off, depth, x0, x1;
    style_t sl, sr;
    span_word_t s;
    s = '0;
    s.row = row_bits;
    row = longint'(row_bits);
    left = longint'($signed(left_q));
    top = longint'($signed(top_q));
    w = longint'(width_q);
    h = longint'(height_q);
    r = longint'(radius_q);
    if (!clip_on) return s;
    if (row < top || row >= top + h) return s;
    if (r > w / 2) r = w / 2;
    if (r > h / 2) r = h / 2;
    if (r == 0) return s;
    off = row - top;
    if (off < r) begin
      depth = off;
      sl = styles_q[1:0];
      sr = styles_q[3:2];
    end else if (off + r >= h) begin
      depth = h - 1 - off;
      sl = styles_q[7:6];
      sr = styles_q[5:4];
    end else begin
      return s;
    end
    x0 = left + corner_inset(sl, r, depth);
    x1 = left + w - corner_inset(sr, r, depth);
    s.span_valid = 1'b1;
    s.x_from = x0[OUT_BITS-1:0];
    s.x_to = x1[OUT_BITS-1:0];
    return s;
  endfunction

  always @(posedge clk) begin : watch
    span_word_t want;
    if (!rst_n) begin
      clip_on = 1'b0;
      left_q = '0;
      top_q = '0;
      width_q = '0;
      height_q = '0;
      radius_q = '0;
      styles_q = '0;
      span_expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (span_expected_q.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("checker: unexpected span word valid=%0d start=%0d end=%0d",
                     out_span_valid, out_span_start, out_span_end);
        end else begin
          want = span_expected_q.pop_front();
          if (out_span_valid !== want.span_valid || out_span_start !== want.x_from ||
              out_span_end !== want.x_to) begin
            mism++;
            if (mism <= 10)
              $display({"checker: row %0d expected valid=%0d start=%0d end=%0d, ",
                        "got valid=%0d start=%0d end=%0d"},
                       want.row, want.span_valid, $signed(want.x_from), $signed(want.x_to),
                       out_span_valid, out_span_start, out_span_end);
          end
        end
      end
      // predict with the registers as they stood before this edge
      if (in_valid && in_ready)
        span_expected_q.push_back(predict_row_span(in_screen_row));
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CLIP_ENABLE:   clip_on = cfg_wdata[0];
          REG_FRAME_LEFT:    left_q = cfg_wdata;
          REG_FRAME_TOP:     top_q = cfg_wdata;
          REG_FRAME_WIDTH:   width_q = cfg_wdata[COORD_BITS-1:0];
          REG_FRAME_HEIGHT:  height_q = cfg_wdata[COORD_BITS-1:0];
          REG_CORNER_RADIUS: radius_q = cfg_wdata[COORD_BITS-1:0];
          REG_CORNER_STYLES: styles_q = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    fail_count <= mism;
    pending_count <= span_expected_q.size();
  end

endmodule

// ----- verif/tb_rounded_frame_row_span_top.sv -----
// Stimulus and verdict for the rounded frame row span block.
`timescale 1ns / 1ps

module tb_rounded_frame_row_span_top
  import rfrs_pkg::*;
();

  localparam int COORD_BITS = COORD_BITS_DEF;
  localparam int POS_BITS   = COORD_BITS + 1;
  localparam int OUT_BITS   = COORD_BITS + 2;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  cfg_idx_t                   cfg_index;
  logic [POS_BITS-1:0]        cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic [COORD_BITS-1:0]      in_screen_row;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_span_valid;
  logic signed [OUT_BITS-1:0] out_span_start;
  logic signed [OUT_BITS-1:0] out_span_end;
  int                         fail_count;
  int                         pending_count;

  bit quiet_phase;
  int hold_off_cycles;

  rounded_frame_row_span_top dut (.*);

  rfrs_span_checker span_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("rounded_frame_row_span_top: mismatch");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when asked
  initial begin : receiver
    int n;
    bit hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0 && !hold_done) begin
        n = hold_off_cycles;
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 99) < 20) begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [POS_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_frame(input bit clip, input int left, input int top, input int w,
                            input int h, input int r, input logic [7:0] styles);
    write_reg(REG_CLIP_ENABLE, POS_BITS'(clip));
    write_reg(REG_FRAME_LEFT, POS_BITS'(left));
    write_reg(REG_FRAME_TOP, POS_BITS'(top));
    write_reg(REG_FRAME_WIDTH, POS_BITS'(w));
    write_reg(REG_FRAME_HEIGHT, POS_BITS'(h));
    write_reg(REG_CORNER_RADIUS, POS_BITS'(r));
    write_reg(REG_CORNER_STYLES, POS_BITS'(styles));
    cfg_we <= 1'b0;
  endtask

  task automatic send_row(input logic [COORD_BITS-1:0] row);
    int gap;
    gap = 0;
    if (!quiet_phase && $urandom_range(0, 99) >= 70)
      gap = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_screen_row <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every predicted span has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int n_items, pick, row_i, r_eff;
    int f_left, f_top, f_w, f_h, f_r;
    bit f_clip;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CLIP_ENABLE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_screen_row = '0;
    quiet_phase = 1'b0;
    hold_off_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset: clipping off
    send_row(12'd0);
    send_row(12'hFFF);
    wait_drained();

    // round top-left, mitre top-right, square bottom-right, code three bottom-left
    load_frame(1'b1, 100, 50, 200, 100, 30,
               {STYLE_PLAIN, STYLE_SQUARE, STYLE_MITRE, STYLE_ROUND});
    send_row(12'd49);
    send_row(12'd50);
    send_row(12'd51);
    send_row(12'd79);
    send_row(12'd80);
    send_row(12'd119);
    send_row(12'd120);
    send_row(12'd149);
    send_row(12'd150);
    wait_drained();

    // largest frame, radius clamped to half the size, all round
    load_frame(1'b1, 4095, 0, 4095, 4095, 4095, {4{STYLE_ROUND}});
    send_row(12'd0);
    send_row(12'd2046);
    send_row(12'd2047);
    send_row(12'd4094);
    send_row(12'd4095);
    wait_drained();

    load_frame(1'b1, -4096, 4095, 4095, 4095, 100, {4{STYLE_MITRE}});
    send_row(12'd4095);
    wait_drained();

    // empty frame
    load_frame(1'b1, 0, 4095, 4095, 0, 100, 8'hFF);
    send_row(12'd4095);
    wait_drained();

    // width below two gives a zero radius
    load_frame(1'b1, 0, 0, 1, 10, 4095, 8'h55);
    send_row(12'd0);
    wait_drained();

    for (int ph = 0; ph < 26; ph++) begin
      quiet_phase = (ph == 2) || ($urandom_range(0, 4) == 0);
      n_items = (ph == 2) ? 80 : $urandom_range(40, 60);
      f_clip = ($urandom_range(0, 9) != 0);
      f_left = int'($urandom_range(0, 8191)) - 4096;
      if ($urandom_range(0, 3) != 0)
        f_top = int'($urandom_range(0, 4000)) - 200;
      else
        f_top = int'($urandom_range(0, 8191)) - 4096;
      pick = $urandom_range(0, 99);
      f_w = (pick < 50) ? $urandom_range(0, 64) :
            (pick < 85) ? $urandom_range(0, 1023) : $urandom_range(0, 4095);
      pick = $urandom_range(0, 99);
      f_h = (pick < 50) ? $urandom_range(0, 64) :
            (pick < 85) ? $urandom_range(0, 1023) : $urandom_range(0, 4095);
      f_r = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 40) : $urandom_range(0, 4095);
      load_frame(f_clip, f_left, f_top, f_w, f_h, f_r, 8'($urandom_range(0, 255)));

      r_eff = f_r;
      if (r_eff > f_w / 2) r_eff = f_w / 2;
      if (r_eff > f_h / 2) r_eff = f_h / 2;

      // stall the result side long enough to back up the whole pipeline
      if (ph == 2) hold_off_cycles = 300;

      for (int k = 0; k < n_items; k++) begin
        pick = $urandom_range(0, 99);
        if (r_eff > 0 && pick < 60) begin
          if (pick < 30)
            row_i = f_top + int'($urandom_range(0, r_eff - 1));
          else
            row_i = f_top + f_h - 1 - int'($urandom_range(0, r_eff - 1));
        end else if (pick < 85) begin
          row_i = f_top - 1 + int'($urandom_range(0, f_h + 1));
        end else begin
          row_i = int'($urandom_range(0, 4095));
        end
        if (row_i < 0 || row_i > 4095) row_i = int'($urandom_range(0, 4095));
        send_row(COORD_BITS'(row_i));
      end
      wait_drained();
    end

    quiet_phase = 1'b0;
    repeat (ROOT_STEPS_DEF + 10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("rounded_frame_row_span_top: match");
    else
      $display("rounded_frame_row_span_top: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rfrs_pkg.sv
sv/rfrs_front.sv
sv/rfrs_root.sv
sv/rounded_frame_row_span_top.sv
verif/rfrs_span_checker.sv
verif/tb_rounded_frame_row_span_top.sv
